FILE: rtl/matrix3x3_inverse_unit_defines.svh
// assertion macros used by the checker file
`ifndef MATRIX3X3_INVERSE_UNIT_DEFINES_SVH
`define MATRIX3X3_INVERSE_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define MI3_ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("mi3 check failed");

// next-cycle implication, checked on clk, off during reset
`define MI3_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("mi3 check failed");

`endif

FILE: rtl/mi3_pkg.sv
// shared types, widths, stage numbers and cofactor index tables
`default_nettype none
package mi3_pkg;
	localparam int NUM_ENT = 9;
	localparam int FW = 32;
	localparam int CW = 65;
	localparam int DW = 100;
	localparam int QB = 31;
	localparam int RW = DW + QB;

	// pipeline stage numbers
	localparam int ST_PROD  = 1;
	localparam int ST_COF   = 2;
	localparam int ST_DPART = 3;
	localparam int ST_DET   = 4;
	localparam int ST_ABS   = 5;
	localparam int ST_SAT   = 6;
	localparam int ST_DIV0  = 7;
	localparam int ST_OUT   = ST_DIV0 + QB;
	localparam int NS       = ST_OUT;

	typedef logic signed [FW-1:0] fix_t;
	typedef logic signed [CW-1:0] cof_t;
	typedef logic signed [DW-1:0] det_t;

	typedef struct packed {
		logic [NS:1] en;
	} pipe_ctl_t;

	// cofactor i = m[PA]*m[PB] - m[RA]*m[RB], m index = row * 3 + column
	localparam int PA [NUM_ENT] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
	localparam int PB [NUM_ENT] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
	localparam int RA [NUM_ENT] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
	localparam int RB [NUM_ENT] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

	// cofactors that pair with row 0 in the determinant expansion
	localparam int DET_COF [3] = '{0, 3, 6};

	localparam fix_t SAT_MAX = 32'sh7FFF_FFFF;
	localparam fix_t SAT_MIN = 32'sh8000_0000;
endpackage
`default_nettype wire

FILE: rtl/mi3_cof.sv
// cofactor stages: eighteen 32x32 products, then nine 2x2 differences
`default_nettype none
module mi3_cof import mi3_pkg::*; (
	input  wire       clk,
	input  pipe_ctl_t ctl,
	input  fix_t      a [NUM_ENT],
	output cof_t      c_s2 [NUM_ENT],
	output fix_t      row0_s2 [3]
);
	logic signed [2*FW-1:0] pp_s1 [NUM_ENT];
	logic signed [2*FW-1:0] pr_s1 [NUM_ENT];
	fix_t                   row0_s1 [3];

	for (genvar i = 0; i < NUM_ENT; i++) begin : g_ent
		// product pairs
		always_ff @(posedge clk) begin
			if (ctl.en[ST_PROD]) begin
				pp_s1[i] <= a[PA[i]] * a[PB[i]];
				pr_s1[i] <= a[RA[i]] * a[RB[i]];
			end
		end
		// cofactor difference
		always_ff @(posedge clk) begin
			if (ctl.en[ST_COF]) begin
				c_s2[i] <= cof_t'(pp_s1[i]) - cof_t'(pr_s1[i]);
			end
		end
	end

	// row 0 travels along for the determinant
	for (genvar j = 0; j < 3; j++) begin : g_row
		always_ff @(posedge clk) begin
			if (ctl.en[ST_PROD]) begin
				row0_s1[j] <= a[j];
			end
			if (ctl.en[ST_COF]) begin
				row0_s2[j] <= row0_s1[j];
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/mi3_det.sv
// determinant stages: split 32x65 products, then sum along row 0
`default_nettype none
module mi3_det import mi3_pkg::*; (
	input  wire       clk,
	input  pipe_ctl_t ctl,
	input  cof_t      c_s2 [NUM_ENT],
	input  fix_t      row0_s2 [3],
	output cof_t      c_s4 [NUM_ENT],
	output det_t      det_s4
);
	localparam int LOW_W = 33;

	logic signed [FW+LOW_W:0] pl_s3 [3];
	logic signed [2*FW-1:0]   ph_s3 [3];
	cof_t                     c_s3 [NUM_ENT];
	det_t                     det_sum;

	// partial products on the low and high halves of each cofactor
	for (genvar j = 0; j < 3; j++) begin : g_part
		always_ff @(posedge clk) begin
			if (ctl.en[ST_DPART]) begin
				pl_s3[j] <= row0_s2[j] * $signed({1'b0, c_s2[DET_COF[j]][LOW_W-1:0]});
				ph_s3[j] <= row0_s2[j] * $signed(c_s2[DET_COF[j]][CW-1:LOW_W]);
			end
		end
	end

	// recombine and add the three terms
	always_comb begin
		det_sum = '0;
		for (int j = 0; j < 3; j++) begin
			det_sum = det_sum + (det_t'(ph_s3[j]) <<< LOW_W) + det_t'(pl_s3[j]);
		end
	end

	// cofactors ride alongside
	for (genvar i = 0; i < NUM_ENT; i++) begin : g_carry
		always_ff @(posedge clk) begin
			if (ctl.en[ST_DPART]) begin
				c_s3[i] <= c_s2[i];
			end
			if (ctl.en[ST_DET]) begin
				c_s4[i] <= c_s3[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[ST_DET]) begin
			det_s4 <= det_sum;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/mi3_lane.sv
// one output lane: magnitudes, overflow check, one quotient bit per stage
`default_nettype none
module mi3_lane import mi3_pkg::*; (
	input  wire            clk,
	input  pipe_ctl_t      ctl,
	input  cof_t           cof,
	input  det_t           det,
	output logic [QB-1:0]  quo,
	output logic           neg,
	output logic           sat
);
	logic [CW-1:0] cmag;
	logic [DW-1:0] dmag;
	logic [RW-1:0] num_s5;
	logic [RW-1:0] den_s5;
	logic          neg_s5;

	logic [RW-1:0] div_rem_s [0:QB];
	logic [RW-1:0] div_den_s [0:QB];
	logic [QB-1:0] div_quo_s [0:QB];
	logic          div_neg_s [0:QB];
	logic          div_sat_s [0:QB];

	// magnitudes and result sign
	assign cmag = cof[CW-1] ? $unsigned(-cof) : $unsigned(cof);
	assign dmag = det[DW-1] ? $unsigned(-det) : $unsigned(det);

	always_ff @(posedge clk) begin
		if (ctl.en[ST_ABS]) begin
			num_s5 <= RW'({cmag, 32'b0});
			den_s5 <= RW'(dmag);
			neg_s5 <= cof[CW-1] ^ det[DW-1];
		end
	end

	// quotient would reach 2^31: saturate
	always_ff @(posedge clk) begin
		if (ctl.en[ST_SAT]) begin
			div_rem_s[0] <= num_s5;
			div_den_s[0] <= den_s5;
			div_quo_s[0] <= '0;
			div_neg_s[0] <= neg_s5;
			div_sat_s[0] <= num_s5 >= (den_s5 << QB);
		end
	end

	// restoring division, most significant quotient bit first
	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [RW-1:0] trial;
		logic          fits;
		assign trial = div_den_s[j] << (QB - 1 - j);
		assign fits  = div_rem_s[j] >= trial;
		always_ff @(posedge clk) begin
			if (ctl.en[ST_DIV0 + j]) begin
				div_rem_s[j+1] <= fits ? div_rem_s[j] - trial : div_rem_s[j];
				div_den_s[j+1] <= div_den_s[j];
				div_quo_s[j+1] <= div_quo_s[j] | (QB'(fits) << (QB - 1 - j));
				div_neg_s[j+1] <= div_neg_s[j];
				div_sat_s[j+1] <= div_sat_s[j];
			end
		end
	end

	assign quo = div_quo_s[QB];
	assign neg = div_neg_s[QB];
	assign sat = div_sat_s[QB];
endmodule
`default_nettype wire

FILE: rtl/matrix3x3_inverse_unit.sv
// top level: 3x3 matrix inverse in signed q16.16 by the adjugate
// Takes one matrix per cycle when the output side keeps up and returns its
// inverse; each stage advances whenever the one after it is empty or moving,
// so a waiting result does not stop new matrices from entering until every
// stage is full. The nine parallel divider lanes resolve one quotient bit per
// stage over 31 stages, after two cofactor stages, two determinant stages and
// two setup stages, with a merge register at the end. Entries are truncated
// toward zero and saturate to the 32-bit range; a zero determinant raises
// singular and returns all zeros.
`default_nettype none
module matrix3x3_inverse_unit import mi3_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire  signed [31:0] a00,
	input  wire  signed [31:0] a01,
	input  wire  signed [31:0] a02,
	input  wire  signed [31:0] a10,
	input  wire  signed [31:0] a11,
	input  wire  signed [31:0] a12,
	input  wire  signed [31:0] a20,
	input  wire  signed [31:0] a21,
	input  wire  signed [31:0] a22,
	output logic              out_valid,
	input  wire               out_ready,
	output logic signed [31:0] b00,
	output logic signed [31:0] b01,
	output logic signed [31:0] b02,
	output logic signed [31:0] b10,
	output logic signed [31:0] b11,
	output logic signed [31:0] b12,
	output logic signed [31:0] b20,
	output logic signed [31:0] b21,
	output logic signed [31:0] b22,
	output logic              singular
);
	pipe_ctl_t     ctl;
	logic [NS:1]   v_q;
	fix_t          a_in [NUM_ENT];
	cof_t          c_s2 [NUM_ENT];
	fix_t          row0_s2 [3];
	cof_t          c_s4 [NUM_ENT];
	det_t          det_s4;
	logic [QB-1:0] lane_quo [NUM_ENT];
	logic          lane_neg [NUM_ENT];
	logic          lane_sat [NUM_ENT];
	logic          sing_s [ST_ABS:ST_OUT-1];
	fix_t          res_s38 [NUM_ENT];
	logic          sing_s38;

	assign a_in[0] = a00;
	assign a_in[1] = a01;
	assign a_in[2] = a02;
	assign a_in[3] = a10;
	assign a_in[4] = a11;
	assign a_in[5] = a12;
	assign a_in[6] = a20;
	assign a_in[7] = a21;
	assign a_in[8] = a22;

	// stage enables: a stage moves when empty or when the next one moves
	always_comb begin
		ctl.en[NS] = !v_q[NS] || out_ready;
		for (int k = NS - 1; k >= 1; k--) begin
			ctl.en[k] = !v_q[k] || ctl.en[k+1];
		end
	end

	assign in_ready  = ctl.en[1];
	assign out_valid = v_q[NS];

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (ctl.en[1]) begin
				v_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (ctl.en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	mi3_cof u_cof (
		.clk     (clk),
		.ctl     (ctl),
		.a       (a_in),
		.c_s2    (c_s2),
		.row0_s2 (row0_s2)
	);

	mi3_det u_det (
		.clk     (clk),
		.ctl     (ctl),
		.c_s2    (c_s2),
		.row0_s2 (row0_s2),
		.c_s4    (c_s4),
		.det_s4  (det_s4)
	);

	for (genvar i = 0; i < NUM_ENT; i++) begin : g_lane
		mi3_lane u_lane (
			.clk (clk),
			.ctl (ctl),
			.cof (c_s4[i]),
			.det (det_s4),
			.quo (lane_quo[i]),
			.neg (lane_neg[i]),
			.sat (lane_sat[i])
		);
	end

	// singular flag follows the lanes
	always_ff @(posedge clk) begin
		if (ctl.en[ST_ABS]) begin
			sing_s[ST_ABS] <= (det_s4 == '0);
		end
		for (int k = ST_ABS + 1; k < ST_OUT; k++) begin
			if (ctl.en[k]) begin
				sing_s[k] <= sing_s[k-1];
			end
		end
	end

	// merge lanes into the output register
	for (genvar i = 0; i < NUM_ENT; i++) begin : g_merge
		always_ff @(posedge clk) begin
			if (ctl.en[ST_OUT]) begin
				if (sing_s[ST_OUT-1]) begin
					res_s38[i] <= '0;
				end else if (lane_sat[i]) begin
					res_s38[i] <= lane_neg[i] ? SAT_MIN : SAT_MAX;
				end else if (lane_neg[i]) begin
					res_s38[i] <= -$signed({1'b0, lane_quo[i]});
				end else begin
					res_s38[i] <= $signed({1'b0, lane_quo[i]});
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[ST_OUT]) begin
			sing_s38 <= sing_s[ST_OUT-1];
		end
	end

	assign b00      = res_s38[0];
	assign b01      = res_s38[1];
	assign b02      = res_s38[2];
	assign b10      = res_s38[3];
	assign b11      = res_s38[4];
	assign b12      = res_s38[5];
	assign b20      = res_s38[6];
	assign b21      = res_s38[7];
	assign b22      = res_s38[8];
	assign singular = sing_s38;
endmodule
`default_nettype wire

FILE: rtl/mi3_checker.sv
// port-level checks for the inverse unit and their bind
`default_nettype none
`include "matrix3x3_inverse_unit_defines.svh"
module mi3_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [31:0] b00,
	input wire [31:0] b01,
	input wire [31:0] b02,
	input wire [31:0] b10,
	input wire [31:0] b11,
	input wire [31:0] b12,
	input wire [31:0] b20,
	input wire [31:0] b21,
	input wire [31:0] b22,
	input wire        singular
);
	logic out_zero;

	// all nine entries of the result are zero
	assign out_zero = (b00 | b01 | b02 | b10 | b11 | b12 | b20 | b21 | b22) == '0;

	// a stalled result stays put, checked on b00 and singular
	`MI3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(b00) && $stable(singular))
	// input backpressure only comes from a stalled, full pipeline
	`MI3_ASSERT_IMPL(a_in_stall, !in_ready, out_valid && !out_ready)
	// a singular matrix gives an all-zero inverse
	`MI3_ASSERT_IMPL(a_sing_zero, out_valid && singular, out_zero)
endmodule

bind matrix3x3_inverse_unit mi3_checker u_mi3_checker (.*);
`default_nettype wire
